>>> hw/rtl/wris_pkg.sv
// ----------------------------------------------------------------------------
// wris_pkg: weighted random index select shared definitions
// Field widths, command and mode codes and parameter defaults used by the
// weighted random index select block.
// ----------------------------------------------------------------------------
package wris_pkg;

	// parameter defaults
	localparam int MAX_ENTRIES_DEF   = 256;
	localparam int WEIGHT_BITS_DEF   = 16;
	localparam int FRACTION_BITS_DEF = 16;

	// port field widths
	localparam int CMD_W      = 1;
	localparam int SLOT_W     = 8;
	localparam int WEIGHT_W   = 16;
	localparam int COUNT_W    = 9;
	localparam int FRAC_W     = 16;
	localparam int SUPPLIED_W = 24;
	localparam int CHOICE_W   = 8;
	localparam int MODE_W     = 1;

	// command codes
	localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
	localparam logic [CMD_W-1:0] CMD_DRAW = 1'b1;

	// select mode codes
	localparam logic [MODE_W-1:0] MODE_SUM_GE      = 1'b0;
	localparam logic [MODE_W-1:0] MODE_SUPPLIED_GT = 1'b1;

endpackage

>>> hw/rtl/weighted_random_index_select.sv
// ----------------------------------------------------------------------------
// weighted_random_index_select: roulette wheel index selection
// Load commands write weights into a two-port weight memory. A draw sums the
// weights in use (or takes a supplied total), scales it by a random fraction
// with a shift-add multiplier and scans the running sums for the first slot
// that reaches the threshold, with a uniform pick as fallback.
// ----------------------------------------------------------------------------
// A load writes the weight memory and leaves the block idle. Mode 0 needs a
// running sum at or above the threshold, mode 1 one above it. A draw reads
// the weights in use for the sum pass (mode 0 only) and the scan, one read
// per cycle, the multiply one fraction bit (16) per cycle. One draw at a time.
// Reset clears control state and select_mode; weights are undefined until
// loaded. done pulses for one cycle with the result and cannot be stalled.
module weighted_random_index_select #(
	parameter int MAX_ENTRIES   = wris_pkg::MAX_ENTRIES_DEF,
	parameter int WEIGHT_BITS   = wris_pkg::WEIGHT_BITS_DEF,
	parameter int FRACTION_BITS = wris_pkg::FRACTION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic [wris_pkg::MODE_W-1:0]       cfg_wdata,
	// command
	input  logic                              start,
	output logic                              busy,
	input  logic [wris_pkg::CMD_W-1:0]        command,
	input  logic [wris_pkg::SLOT_W-1:0]       slot,
	input  logic [wris_pkg::WEIGHT_W-1:0]     weight,
	input  logic [wris_pkg::COUNT_W-1:0]      count,
	input  logic [wris_pkg::FRAC_W-1:0]       random_fraction,
	input  logic [wris_pkg::SUPPLIED_W-1:0]   supplied_total,
	input  logic [wris_pkg::FRAC_W-1:0]       spare_random,
	// result
	output logic                              done,
	output logic [wris_pkg::CHOICE_W-1:0]     choice,
	output logic                              used_fallback
);
	import wris_pkg::*;

	localparam int IDX_W     = $clog2(MAX_ENTRIES);
	localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
	localparam int ACC_W     = WEIGHT_BITS + IDX_W;
	localparam int SUM_W     = (ACC_W > SUPPLIED_W) ? ACC_W : SUPPLIED_W;
	localparam int PROD_W    = SUM_W + FRAC_W;
	localparam int FB_PROD_W = FRAC_W + CNT_W;
	localparam int STEP_W    = $clog2(FRAC_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FRAC_W - 1);
	localparam logic [FRAC_W-1:0] FRAC_MASK = (FRACTION_BITS >= FRAC_W) ?
		{FRAC_W{1'b1}} : FRAC_W'((64'd1 << FRACTION_BITS) - 64'd1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_MUL,
		ST_SCAN
	} state_t;

	state_t                  state_q;
	logic [MODE_W-1:0]       mode_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        issue_q;
	logic [FRAC_W-1:0]       frac_q;
	logic [FRAC_W-1:0]       spare_q;
	logic [SUM_W-1:0]        acc_q;
	logic [PROD_W-1:0]       mcand_q;
	logic [PROD_W-1:0]       prod_q;
	logic [STEP_W-1:0]       step_q;
	logic                    done_q;
	logic [CHOICE_W-1:0]     choice_q;
	logic                    fallback_q;

	logic                    rd_valid_s1;
	logic [IDX_W-1:0]        rd_idx_s1;
	logic [WEIGHT_BITS-1:0]  rd_data_s1;

	logic [WEIGHT_BITS-1:0]  weight_mem [MAX_ENTRIES];

	logic                    accept;
	logic                    mem_we;
	logic [IDX_W-1:0]        rd_addr;
	logic                    rd_en;
	logic                    issue_done;
	logic [SUM_W-1:0]        sum_next;
	logic [SUM_W-1:0]        threshold;
	logic                    hit;
	logic [FB_PROD_W-1:0]    fb_prod;
	logic [CHOICE_W-1:0]     fb_choice;
	logic [CNT_W-1:0]        count_sat;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign mem_we   = accept && (command == CMD_LOAD) && (32'(slot) < MAX_ENTRIES);

	// read issue for the sum pass and the scan
	assign rd_addr    = issue_q[IDX_W-1:0];
	assign issue_done = (issue_q == count_q);
	assign rd_en      = ((state_q == ST_SUM) || (state_q == ST_SCAN)) && !issue_done;

	// running sum, threshold and compare
	assign sum_next  = acc_q + SUM_W'(rd_data_s1);
	assign threshold = SUM_W'(prod_q >> FRACTION_BITS);
	assign hit       = (mode_q == MODE_SUPPLIED_GT) ? (sum_next > threshold)
	                                                 : (sum_next >= threshold);

	// uniform fallback pick
	assign fb_prod   = FB_PROD_W'(spare_q) * FB_PROD_W'(count_q);
	assign fb_choice = CHOICE_W'(fb_prod >> FRACTION_BITS);

	// count saturated to the store depth
	assign count_sat = (32'(count) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES) : CNT_W'(count);

	// weight memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			weight_mem[IDX_W'(slot)] <= WEIGHT_BITS'(weight);
		end
		rd_data_s1 <= weight_mem[rd_addr];
		rd_idx_s1  <= rd_addr;
	end

	// sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_SUM_GE;
			count_q     <= '0;
			issue_q     <= '0;
			frac_q      <= '0;
			spare_q     <= '0;
			acc_q       <= '0;
			mcand_q     <= '0;
			prod_q      <= '0;
			step_q      <= '0;
			done_q      <= 1'b0;
			choice_q    <= '0;
			fallback_q  <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			done_q      <= 1'b0;
			rd_valid_s1 <= rd_en;
			if (rd_en) begin
				issue_q <= issue_q + CNT_W'(1);
			end
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end

			unique case (state_q)
				ST_IDLE: begin
					// draw transfer: latch operands and pick the total source
					if (accept && (command == CMD_DRAW)) begin
						count_q <= count_sat;
						frac_q  <= random_fraction & FRAC_MASK;
						spare_q <= spare_random & FRAC_MASK;
						issue_q <= '0;
						acc_q   <= '0;
						prod_q  <= '0;
						step_q  <= '0;
						mcand_q <= PROD_W'(supplied_total);
						if (mode_q == MODE_SUPPLIED_GT) begin
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_SUM;
						end
					end
				end

				ST_SUM: begin
					// total of the weights in use
					if (rd_valid_s1) begin
						acc_q <= sum_next;
					end else if (issue_done) begin
						mcand_q <= PROD_W'(acc_q);
						state_q <= ST_MUL;
					end
				end

				ST_MUL: begin
					// shift-add multiply, one fraction bit per cycle
					prod_q  <= prod_q + (frac_q[0] ? mcand_q : '0);
					mcand_q <= mcand_q << 1;
					frac_q  <= frac_q >> 1;
					step_q  <= step_q + STEP_W'(1);
					if (step_q == LAST_STEP) begin
						issue_q <= '0;
						acc_q   <= '0;
						state_q <= ST_SCAN;
					end
				end

				ST_SCAN: begin
					// first slot whose running sum qualifies
					if (rd_valid_s1) begin
						acc_q <= sum_next;
						if (hit) begin
							choice_q   <= CHOICE_W'(rd_idx_s1);
							fallback_q <= 1'b0;
							done_q     <= 1'b1;
							state_q    <= ST_IDLE;
						end
					end else if (issue_done) begin
						choice_q   <= fb_choice;
						fallback_q <= 1'b1;
						done_q     <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done          = done_q;
	assign choice        = choice_q;
	assign used_fallback = fallback_q;

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb: weighted random index select testbench
// Fills the weight memory, walks a short table of directed loads and draws
// in both select modes, then runs random load/draw traffic in phases with
// different sender gaps. Every draw result is compared field by field with
// the typed pick of its table row or with a behavioral roulette wheel kept in step with the accepted commands.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wris_pkg::*;

	localparam int ITEMS_PER_PHASE = 222;
	localparam int DRAIN_CYCLES    = 600;
	localparam int WHEEL_ACC_W     = SUPPLIED_W + 1;

	typedef struct packed {
		logic [CMD_W-1:0]      cmd;
		logic [SLOT_W-1:0]     slot;
		logic [WEIGHT_W-1:0]   weight;
		logic [COUNT_W-1:0]    count;
		logic [FRAC_W-1:0]     frac;
		logic [SUPPLIED_W-1:0] supplied;
		logic [FRAC_W-1:0]     spare;
	} wris_cmd_t;

	typedef struct packed {
		logic [CHOICE_W-1:0] choice;
		logic                fallback;
	} pick_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		wris_cmd_t         cmd;
		logic              typed;
		pick_t             pick;
	} dir_row_t;

	localparam pick_t NO_PICK = '{8'd0, 1'b0};

	// directed rows; typed picks only where the answer is obvious
	localparam dir_row_t DIRECTED [0:24] = '{
		'{MODE_SUM_GE, '{CMD_LOAD, 8'd0, 16'd0, 9'd0, 16'd0, 24'd0, 16'd0}, 1'b0, NO_PICK},
		'{MODE_SUM_GE, '{CMD_LOAD, 8'd255, 16'hFFFF, 9'd0, 16'd0, 24'd0, 16'd0}, 1'b0, NO_PICK},
		'{MODE_SUM_GE, '{CMD_LOAD, 8'd1, 16'hFFFF, 9'd0, 16'd0, 24'd0, 16'd0}, 1'b0, NO_PICK},
		'{MODE_SUM_GE, '{CMD_DRAW, 8'd0, 16'd0, 9'd0, 16'h8000, 24'd0, 16'hFFFF}, 1'b1,
			'{8'd0, 1'b1}},
		'{MODE_SUM_GE, '{CMD_DRAW, 8'd0, 16'd0, 9'd1, 16'h0000, 24'd0, 16'h1234}, 1'b1,
			'{8'd0, 1'b0}},
		'{MODE_SUM_GE, '{CMD_DRAW, 8'd0, 16'd0, 9'd1, 16'hFFFF, 24'd0, 16'h1234}, 1'b1,
			'{8'd0, 1'b0}},
		'{MODE_SUM_GE, '{CMD_DRAW, 8'd0, 16'd0, 9'd2, 16'hFFFF, 24'd0, 16'h0000}, 1'b1,
			'{8'd1, 1'b0}},
		'{MODE_SUM_GE, '{CMD_DRAW, 8'd0, 16'd0, 9'd256, 16'hFFFF, 24'd0, 16'h0000}, 1'b0,
			NO_PICK},
		'{MODE_SUM_GE, '{CMD_DRAW, 8'd0, 16'd0, 9'd511, 16'h0000, 24'hFFFFFF, 16'hFFFF},
			1'b1, '{8'd0, 1'b0}},
		'{MODE_SUM_GE, '{CMD_DRAW, 8'd0, 16'd0, 9'd511, 16'hFFFF, 24'd0, 16'hFFFF}, 1'b0,
			NO_PICK},
		'{MODE_SUM_GE, '{CMD_DRAW, 8'd0, 16'd0, 9'd300, 16'h8000, 24'd0, 16'h0000}, 1'b0,
			NO_PICK},
		// load with every draw field at its top value
		'{MODE_SUM_GE, '{CMD_LOAD, 8'd2, 16'd7, 9'd511, 16'hFFFF, 24'hFFFFFF, 16'hFFFF},
			1'b0, NO_PICK},
		'{MODE_SUPPLIED_GT, '{CMD_DRAW, 8'd0, 16'd0, 9'd2, 16'hFFFF, 24'd0, 16'h0000}, 1'b1,
			'{8'd1, 1'b0}},
		'{MODE_SUPPLIED_GT, '{CMD_DRAW, 8'd0, 16'd0, 9'd1, 16'hFFFF, 24'd0, 16'hFFFF}, 1'b1,
			'{8'd0, 1'b1}},
		// supplied total far above the real sum forces the uniform pick
		'{MODE_SUPPLIED_GT, '{CMD_DRAW, 8'd0, 16'd0, 9'd256, 16'hFFFF, 24'hFFFFFF,
			16'hFFFF}, 1'b1, '{8'd255, 1'b1}},
		'{MODE_SUPPLIED_GT, '{CMD_DRAW, 8'd0, 16'd0, 9'd511, 16'hFFFF, 24'hFFFFFF,
			16'h0000}, 1'b1, '{8'd0, 1'b1}},
		'{MODE_SUPPLIED_GT, '{CMD_DRAW, 8'd0, 16'd0, 9'd511, 16'hFFFF, 24'hFFFFFF,
			16'h8000}, 1'b1, '{8'd128, 1'b1}},
		'{MODE_SUPPLIED_GT, '{CMD_DRAW, 8'd0, 16'd0, 9'd3, 16'h8000, 24'd65536, 16'h0000},
			1'b1, '{8'd1, 1'b0}},
		'{MODE_SUPPLIED_GT, '{CMD_DRAW, 8'd0, 16'd0, 9'd4, 16'hFFFF, 24'd131077, 16'h4321},
			1'b0, NO_PICK},
		'{MODE_SUPPLIED_GT, '{CMD_DRAW, 8'd0, 16'd0, 9'd256, 16'hFFFF, 24'd1, 16'h0000},
			1'b1, '{8'd1, 1'b0}},
		'{MODE_SUM_GE, '{CMD_LOAD, 8'd0, 16'hFFFF, 9'd0, 16'd0, 24'd0, 16'd0}, 1'b0, NO_PICK},
		'{MODE_SUM_GE, '{CMD_DRAW, 8'd0, 16'd0, 9'd256, 16'h0001, 24'd0, 16'h0000}, 1'b0,
			NO_PICK},
		'{MODE_SUM_GE, '{CMD_DRAW, 8'd0, 16'd0, 9'd1, 16'h8000, 24'd0, 16'h0000}, 1'b1,
			'{8'd0, 1'b0}},
		'{MODE_SUM_GE, '{CMD_LOAD, 8'd255, 16'd0, 9'd0, 16'd0, 24'd0, 16'd0}, 1'b0, NO_PICK},
		'{MODE_SUM_GE, '{CMD_DRAW, 8'd0, 16'd0, 9'd256, 16'hFFFF, 24'd0, 16'h0000}, 1'b0,
			NO_PICK}
	};

	// random phases: select mode and sender idle percentage
	localparam logic [MODE_W-1:0] PHASE_MODE [0:3] = '{MODE_SUPPLIED_GT, MODE_SUM_GE,
		MODE_SUPPLIED_GT, MODE_SUM_GE};
	localparam int unsigned PHASE_IDLE [0:3] = '{0, 72, 0, 18};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [MODE_W-1:0]     cfg_wdata;
	logic                  start;
	logic                  busy;
	logic [CMD_W-1:0]      command;
	logic [SLOT_W-1:0]     slot;
	logic [WEIGHT_W-1:0]   weight;
	logic [COUNT_W-1:0]    count;
	logic [FRAC_W-1:0]     random_fraction;
	logic [SUPPLIED_W-1:0] supplied_total;
	logic [FRAC_W-1:0]     spare_random;
	logic                  done;
	logic [CHOICE_W-1:0]   choice;
	logic                  used_fallback;

	// model state: wheel weights and current select mode
	logic [WEIGHT_W-1:0]   wheel [0:MAX_ENTRIES_DEF-1];
	logic [MODE_W-1:0]     sel_mode;
	pick_t                 pending_picks [$];
	int unsigned           mismatch_count;

	weighted_random_index_select i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.start           (start),
		.busy            (busy),
		.command         (command),
		.slot            (slot),
		.weight          (weight),
		.count           (count),
		.random_fraction (random_fraction),
		.supplied_total  (supplied_total),
		.spare_random    (spare_random),
		.done            (done),
		.choice          (choice),
		.used_fallback   (used_fallback)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#25_000_000;
		$display("weighted_random_index_select test failed");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		mismatch_count++;
		$display("%0t ns mismatch: %s", $time, what);
	endtask

	// sum of the first n wheel weights
	function automatic logic [SUPPLIED_W-1:0] wheel_total(input int unsigned n);
		logic [SUPPLIED_W:0] acc;
		acc = '0;
		for (int unsigned i = 0; i < n; i++)
			acc += WHEEL_ACC_W'(wheel[i]);
		return acc[SUPPLIED_W-1:0];
	endfunction

	// roulette wheel: apply one command, return 1 with a pick for a draw
	function automatic bit roulette_pick(input wris_cmd_t c, output pick_t pick);
		int unsigned          n;
		logic [SUPPLIED_W-1:0] total;
		logic [47:0]          threshold;
		logic [SUPPLIED_W:0]  acc;
		bit                   hit;
		pick = NO_PICK;
		if (c.cmd == CMD_LOAD) begin
			wheel[c.slot] = c.weight;
			return 1'b0;
		end
		n = (32'(c.count) > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : 32'(c.count);
		total = (sel_mode == MODE_SUM_GE) ? wheel_total(n) : c.supplied;
		threshold = (48'(c.frac) * 48'(total)) >> FRAC_W;
		acc = '0;
		hit = 1'b0;
		// scan running sums for the first qualifying slot
		for (int unsigned i = 0; i < n && !hit; i++) begin
			acc += WHEEL_ACC_W'(wheel[i]);
			if (sel_mode == MODE_SUM_GE ? (48'(acc) >= threshold) : (48'(acc) > threshold)) begin
				hit = 1'b1;
				pick.choice = i[CHOICE_W-1:0];
			end
		end
		// uniform pick when nothing qualified
		if (!hit) begin
			pick.choice = CHOICE_W'((32'(c.spare) * n) >> FRAC_W);
			pick.fallback = 1'b1;
		end
		return 1'b1;
	endfunction

	// random command, mostly small draws, supplied totals near the real sum
	function automatic wris_cmd_t random_cmd();
		wris_cmd_t             c;
		int unsigned           r;
		int unsigned           n;
		logic [SUPPLIED_W-1:0] sum;
		c.cmd = ($urandom_range(99) < 40) ? CMD_LOAD : CMD_DRAW;
		c.slot = SLOT_W'($urandom);
		c.frac = FRAC_W'($urandom);
		c.supplied = SUPPLIED_W'($urandom);
		c.spare = FRAC_W'($urandom);
		r = $urandom_range(99);
		if (r < 10)
			c.weight = '0;
		else if (r < 20)
			c.weight = '1;
		else if (r < 50)
			c.weight = WEIGHT_W'($urandom_range(15));
		else
			c.weight = WEIGHT_W'($urandom);
		r = $urandom_range(99);
		if (r < 5)
			c.count = '0;
		else if (r < 75)
			c.count = COUNT_W'($urandom_range(1, 16));
		else if (r < 88)
			c.count = COUNT_W'($urandom_range(17, 255));
		else
			c.count = COUNT_W'($urandom_range(256, 511));
		r = $urandom_range(99);
		if (r < 8)
			c.frac = '0;
		else if (r < 16)
			c.frac = '1;
		if (sel_mode == MODE_SUPPLIED_GT) begin
			n = (32'(c.count) > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : 32'(c.count);
			sum = wheel_total(n);
			r = $urandom_range(99);
			if (r < 35)
				c.supplied = sum;
			else if (r < 55)
				c.supplied = sum + SUPPLIED_W'($urandom_range(1, 4));
			else if (r < 70)
				c.supplied = SUPPLIED_W'($urandom_range(0, 32'(sum)));
			else if (r < 80)
				c.supplied = '0;
			else if (r < 90)
				c.supplied = '1;
		end
		return c;
	endfunction

	// present a command and wait for its transfer
	task automatic send_cmd(input wris_cmd_t c, input bit typed, input pick_t typed_pick);
		pick_t p;
		bit    has_pick;
		start <= 1'b1;
		command <= c.cmd;
		slot <= c.slot;
		weight <= c.weight;
		count <= c.count;
		random_fraction <= c.frac;
		supplied_total <= c.supplied;
		spare_random <= c.spare;
		do
			@(posedge clk);
		while (busy);
		has_pick = roulette_pick(c, p);
		if (has_pick)
			pending_picks.push_back(typed ? typed_pick : p);
	endtask

	// random sender gap
	task automatic sender_gap(input int unsigned pct);
		if ($urandom_range(99) < pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < pct);
		end
	endtask

	// write select_mode once the block has gone idle
	task automatic set_mode(input logic [MODE_W-1:0] m);
		start <= 1'b0;
		@(posedge clk);
		while (pending_picks.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		sel_mode = m;
	endtask

	// result checker
	always @(posedge clk) begin
		pick_t want;
		if (arst_n && done) begin
			if (pending_picks.size() == 0) begin
				flag_mismatch($sformatf("unexpected result choice=%0d", choice));
			end else begin
				want = pending_picks.pop_front();
				if (choice !== want.choice)
					flag_mismatch($sformatf("choice got %0d want %0d", choice, want.choice));
				if (used_fallback !== want.fallback)
					flag_mismatch($sformatf("used_fallback got %0b want %0b", used_fallback,
						want.fallback));
			end
		end
	end

	// stimulus
	initial begin
		wris_cmd_t c;
		mismatch_count = 0;
		sel_mode = MODE_SUM_GE;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		start <= 1'b0;
		command <= CMD_LOAD;
		slot <= '0;
		weight <= '0;
		count <= '0;
		random_fraction <= '0;
		supplied_total <= '0;
		spare_random <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_mode(MODE_SUM_GE);

		// give every slot a weight so no draw reads an empty slot
		for (int i = 0; i < MAX_ENTRIES_DEF; i++) begin
			c = '{CMD_LOAD, SLOT_W'(i), 16'd1, 9'd0, 16'd0, 24'd0, 16'd0};
			send_cmd(c, 1'b0, NO_PICK);
		end

		// directed table
		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].mode != sel_mode)
				set_mode(DIRECTED[i].mode);
			send_cmd(DIRECTED[i].cmd, DIRECTED[i].typed, DIRECTED[i].pick);
		end

		// random phases
		for (int p = 0; p < 4; p++) begin
			set_mode(PHASE_MODE[p]);
			repeat (ITEMS_PER_PHASE) begin
				send_cmd(random_cmd(), 1'b0, NO_PICK);
				sender_gap(PHASE_IDLE[p]);
			end
		end

		// drain
		start <= 1'b0;
		while (pending_picks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("weighted_random_index_select test passed");
		else
			$display("weighted_random_index_select test failed");
		$finish;
	end

endmodule
